[hdl/mtep_pkg.sv]
// Shared types, codes and constants of the MIDI track event parser.
package mtep_pkg;

  localparam int NOTE_AW = 11;
  localparam logic [NOTE_AW-1:0] NOTE_LAST = '1;

  // Parse phases.
  localparam logic [3:0] PH_DELTA  = 4'd0;
  localparam logic [3:0] PH_STATUS = 4'd1;
  localparam logic [3:0] PH_DATA1  = 4'd2;
  localparam logic [3:0] PH_DATA2  = 4'd3;
  localparam logic [3:0] PH_MTYPE  = 4'd4;
  localparam logic [3:0] PH_MLEN   = 4'd5;
  localparam logic [3:0] PH_MBODY  = 4'd6;
  localparam logic [3:0] PH_SLEN   = 4'd7;
  localparam logic [3:0] PH_SBODY  = 4'd8;

  // Result kinds.
  localparam logic [2:0] K_NOTE  = 3'd0;
  localparam logic [2:0] K_CC    = 3'd1;
  localparam logic [2:0] K_TEMPO = 3'd2;
  localparam logic [2:0] K_TSIG  = 3'd3;
  localparam logic [2:0] K_END   = 3'd4;
  localparam logic [2:0] K_DRAIN = 3'd5;
  localparam logic [2:0] K_ERR   = 3'd6;

  // Error codes.
  localparam logic [1:0] ERR_NO_STATUS = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
  localparam logic [1:0] ERR_CUT       = 2'd2;

  // Status and meta bytes.
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [3:0] TY_NOTE_OFF = 4'h8;
  localparam logic [3:0] TY_NOTE_ON  = 4'h9;
  localparam logic [3:0] TY_CTRL     = 4'hB;
  localparam logic [3:0] TY_PROG     = 4'hC;
  localparam logic [3:0] TY_PRESS    = 4'hD;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TSIG   = 8'h58;
  localparam logic [7:0] META_EOT    = 8'h2F;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_ON,
    MOP_OFF
  } mem_op_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_in_track;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  level;
    logic [31:0] start_tick;
    logic [31:0] duration_ticks;
    logic [23:0] tempo_us;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator_log;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_req_t;

  typedef struct packed {
    logic        valid;
    logic [6:0]  vel;
    logic [31:0] start;
  } note_ent_t;

  typedef struct packed {
    mem_op_e           op;
    logic [NOTE_AW-1:0] idx;
    logic [6:0]        vel;
    logic [31:0]       start;
  } note_cmd_t;

  typedef struct packed {
    logic [7:0]  running_status;
    logic [7:0]  current_status;
    logic [3:0]  phase;
    logic [31:0] vlq_acc;
    logic [2:0]  vlq_cnt;
    logic [7:0]  meta_type;
    logic [31:0] bytes_rem;
    logic [23:0] payload;
    logic [7:0]  first_data;
    logic        err;
    logic        skip;
  } pars_state_t;

  localparam pars_state_t PARS_RESET = '0;

  function automatic out_req_t mk_res(logic [2:0] kind, logic [31:0] start);
    out_req_t r;
    r = '0;
    r.kind = kind;
    r.start_tick = start;
    return r;
  endfunction

endpackage

[hdl/mtep_note_mem.sv]
// Open-note table: one write port and one registered read port.
module mtep_note_mem import mtep_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [NOTE_AW-1:0] waddr_i,
  input  note_ent_t          wdata_i,
  input  logic               re_i,
  input  logic [NOTE_AW-1:0] raddr_i,
  output note_ent_t          rdata_o
);

  note_ent_t mem [2**NOTE_AW];
  note_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mtep_out_fifo.sv]
// Four-entry result queue that takes up to two results per cycle.
module mtep_out_fifo import mtep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_a_i,
  input  out_req_t data_a_i,
  input  logic     push_b_i,
  input  out_req_t data_b_i,
  output logic     valid_o,
  input  logic     stall_i,
  output out_req_t data_o,
  output logic [2:0] count_o
);

  out_req_t   ent_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] npush;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = ent_q[rd_q];
  assign count_o = cnt_q;
  assign pop     = valid_o && !stall_i;
  assign npush   = {1'b0, push_a_i} + {1'b0, push_b_i};
  assign wr_d    = wr_q + npush;
  assign rd_d    = rd_q + {1'b0, pop};
  assign cnt_d   = cnt_q + {1'b0, npush} - {2'b00, pop};

  // The second result of a cycle only comes with a first one.
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      ent_q[wr_q] <= data_a_i;
    end
    if (push_b_i) begin
      ent_q[wr_q + 2'd1] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/mtep_parser.sv]
// Byte decoder: next parse state, tick count, results and table command.
module mtep_parser import mtep_pkg::*; #(
  parameter int VLQ_MAX_BYTES = 4,
  parameter int TICK_BITS     = 32
) (
  input  pars_state_t          state_i,
  input  logic [TICK_BITS-1:0] tick_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output pars_state_t          state_o,
  output logic [TICK_BITS-1:0] tick_o,
  output out_req_t             res0_o,
  output logic                 res0_valid_o,
  output out_req_t             res1_o,
  output logic                 res1_valid_o,
  output note_cmd_t            cmd_o,
  output logic                 track_end_o
);

  localparam int SUMW = (TICK_BITS > 32) ? TICK_BITS : 32;

  function automatic logic [TICK_BITS-1:0] tadd(logic [TICK_BITS-1:0] a, logic [31:0] b);
    logic [SUMW-1:0] sm;
    sm = SUMW'(a) + SUMW'(b);
    return sm[TICK_BITS-1:0];
  endfunction

  pars_state_t          s;
  logic [TICK_BITS-1:0] t;
  logic [31:0]          acc_n;
  logic [2:0]           cnt_n;
  logic                 vdone;
  logic                 carried;
  logic                 do_d1, do_d2, do_meta;
  out_req_t             fres, eres, tres;
  logic                 fv, ev, tv;
  note_cmd_t            cmd;
  logic [6:0]           v;

  always_comb begin
    s       = state_i;
    t       = tick_i;
    fres    = '0;
    eres    = '0;
    tres    = '0;
    fv      = 1'b0;
    ev      = 1'b0;
    tv      = 1'b0;
    do_d1   = 1'b0;
    do_d2   = 1'b0;
    do_meta = 1'b0;
    cmd     = '0;
    cmd.op  = MOP_NONE;
    carried = !byte_i[7];
    v       = byte_i[6:0];
    acc_n   = {state_i.vlq_acc[24:0], byte_i[6:0]};
    cnt_n   = state_i.vlq_cnt + 3'd1;
    vdone   = !byte_i[7] || (cnt_n >= 3'(VLQ_MAX_BYTES));

    if (!s.err && !s.skip) begin
      case (s.phase)
        PH_DELTA: begin
          s.vlq_acc = acc_n;
          s.vlq_cnt = cnt_n;
          if (vdone) begin
            t = tadd(t, acc_n);
            s.phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (carried && s.running_status == 8'h00) begin
            fres = mk_res(K_ERR, 32'(t));
            fres.error_code = ERR_NO_STATUS;
            fv = 1'b1;
            s.err = 1'b1;
          end else begin
            s.current_status = carried ? s.running_status : byte_i;
            if (!carried && byte_i < ST_SYSEX) begin
              s.running_status = byte_i;
            end
            if (s.current_status == ST_META) begin
              s.phase = PH_MTYPE;
            end else if (s.current_status == ST_SYSEX || s.current_status == ST_SYSEX_CT) begin
              s.vlq_acc = '0;
              s.vlq_cnt = '0;
              s.phase = PH_SLEN;
            end else if (s.current_status >= ST_SYSEX) begin
              fres = mk_res(K_ERR, 32'(t));
              fres.error_code = ERR_UNKNOWN;
              fv = 1'b1;
              s.err = 1'b1;
            end else begin
              s.phase = PH_DATA1;
              do_d1 = carried;
            end
          end
        end
        PH_DATA1: do_d1 = 1'b1;
        PH_DATA2: do_d2 = 1'b1;
        PH_MTYPE: begin
          s.meta_type = byte_i;
          s.vlq_acc = '0;
          s.vlq_cnt = '0;
          s.phase = PH_MLEN;
        end
        PH_MLEN: begin
          s.vlq_acc = acc_n;
          s.vlq_cnt = cnt_n;
          if (vdone) begin
            s.bytes_rem = acc_n;
            s.payload = '0;
            if (acc_n == 32'd0) begin
              do_meta = 1'b1;
            end else begin
              s.phase = PH_MBODY;
            end
          end
        end
        PH_MBODY: begin
          // Only the first three payload bytes are kept.
          if ((s.vlq_acc - s.bytes_rem) < 32'd3) begin
            s.payload = {s.payload[15:0], byte_i};
          end
          s.bytes_rem = s.bytes_rem - 32'd1;
          if (s.bytes_rem == 32'd0) begin
            do_meta = 1'b1;
          end
        end
        PH_SLEN: begin
          s.vlq_acc = acc_n;
          s.vlq_cnt = cnt_n;
          if (vdone) begin
            s.bytes_rem = acc_n;
            if (acc_n == 32'd0) begin
              s.phase = PH_DELTA;
              s.vlq_acc = '0;
              s.vlq_cnt = '0;
            end else begin
              s.phase = PH_SBODY;
            end
          end
        end
        PH_SBODY: begin
          s.bytes_rem = s.bytes_rem - 32'd1;
          if (s.bytes_rem == 32'd0) begin
            s.phase = PH_DELTA;
            s.vlq_acc = '0;
            s.vlq_cnt = '0;
          end
        end
        default: begin
          s.phase = PH_DELTA;
          s.vlq_acc = '0;
          s.vlq_cnt = '0;
        end
      endcase

      if (do_d1) begin
        s.first_data = byte_i;
        if (s.current_status[7:4] == TY_PROG || s.current_status[7:4] == TY_PRESS) begin
          s.phase = PH_DATA1;
          s.phase = PH_DELTA;
          s.vlq_acc = '0;
          s.vlq_cnt = '0;
        end else begin
          s.phase = PH_DATA2;
        end
      end

      if (do_d2) begin
        cmd.idx = {s.current_status[3:0], s.first_data[6:0]};
        cmd.vel = v;
        cmd.start = 32'(t);
        if (s.current_status[7:4] == TY_NOTE_OFF ||
            (s.current_status[7:4] == TY_NOTE_ON && v == 7'd0)) begin
          cmd.op = MOP_OFF;
        end else if (s.current_status[7:4] == TY_NOTE_ON) begin
          cmd.op = MOP_ON;
        end else if (s.current_status[7:4] == TY_CTRL) begin
          fres = mk_res(K_CC, 32'(t));
          fres.channel = s.current_status[3:0];
          fres.key = s.first_data[6:0];
          fres.level = v;
          fv = 1'b1;
        end
        s.phase = PH_DELTA;
        s.vlq_acc = '0;
        s.vlq_cnt = '0;
      end

      if (do_meta) begin
        if (s.meta_type == META_TEMPO && s.vlq_acc == 32'd3 && s.payload != 24'd0) begin
          fres = mk_res(K_TEMPO, 32'(t));
          fres.tempo_us = s.payload;
          fv = 1'b1;
        end else if (s.meta_type == META_TSIG && s.vlq_acc == 32'd4) begin
          fres = mk_res(K_TSIG, 32'(t));
          fres.sig_numerator = s.payload[23:16];
          fres.sig_denominator_log = s.payload[15:8];
          fv = 1'b1;
        end else if (s.meta_type == META_EOT) begin
          s.skip = 1'b1;
        end
        s.phase = PH_DELTA;
        s.vlq_acc = '0;
        s.vlq_cnt = '0;
      end
    end

    if (last_i) begin
      if (!s.err && !s.skip) begin
        if (s.phase != PH_DELTA) begin
          eres = mk_res(K_ERR, 32'(t));
          eres.error_code = ERR_CUT;
          ev = 1'b1;
          s.err = 1'b1;
        end else if (s.vlq_cnt != 3'd0) begin
          // A delta time cut short still counts.
          t = tadd(t, s.vlq_acc);
        end
      end
      tres = mk_res(K_END, 32'(t));
      tres.duration_ticks = 32'(t);
      tv = 1'b1;
    end
  end

  always_comb begin
    res0_o = fv ? fres : (ev ? eres : tres);
    res0_valid_o = fv || ev || tv;
    res1_o = tres;
    res1_valid_o = (fv || ev) && tv;
    res0_o.last_of_run = !res1_valid_o;
    res1_o.last_of_run = 1'b1;
  end

  assign state_o     = s;
  assign tick_o      = t;
  assign cmd_o       = cmd;
  assign track_end_o = last_i;

endmodule

[hdl/midi_track_event_parser.sv]
// Top level of the MIDI track event parser.
// Takes one track byte or drain request per accepted item and returns note, control change,
// tempo, time signature, track end, drain done and error results through a four-entry queue.
// The input stalls while the queue holds more than two results. The byte that closes a
// note-off passes through the note state, as it reads the open-note table through its
// single registered read port. After a drain request is accepted, the table is scanned
// entry by entry through the scan and check states; an open note found ends the scan with
// its note result and clears its entry, else the scan ends in the drain done result. After
// reset a clearing pass runs through all 2048 entries. The first byte after a track end is
// seen, then held through a clearing pass. No item is accepted during a scan or clearing pass.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int VLQ_MAX_BYTES = 4,
  parameter int TICK_BITS     = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_data_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_NOTE  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_SCHK  = 3'd4;

  localparam logic [31:0] DUR_MASK =
    (TICK_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TICK_BITS) - 64'd1);

  logic [2:0]           state_q, state_d;
  logic [NOTE_AW-1:0]   idx_q, idx_d;
  pars_state_t          pst_q, pst_d, pst_n;
  logic [TICK_BITS-1:0] tick_q, tick_d, tick_n;
  logic                 done_q, done_d;
  out_req_t             pend_q, pend_d;
  logic                 pend_v_q, pend_v_d;

  out_req_t  r0, r1, note_res, drain_res;
  logic      r0v, r1v, trk_end;
  note_cmd_t cmd;

  logic       push_a, push_b;
  out_req_t   data_a, data_b;
  logic [2:0] fifo_cnt;

  logic               we, re;
  logic [NOTE_AW-1:0] waddr, raddr;
  note_ent_t          wdata, rdata;

  logic room, accept;

  mtep_parser #(
    .VLQ_MAX_BYTES(VLQ_MAX_BYTES),
    .TICK_BITS(TICK_BITS)
  ) u_parser (
    .state_i(pst_q),
    .tick_i(tick_q),
    .byte_i(in_data_i.data_byte),
    .last_i(in_data_i.last_in_track),
    .state_o(pst_n),
    .tick_o(tick_n),
    .res0_o(r0),
    .res0_valid_o(r0v),
    .res1_o(r1),
    .res1_valid_o(r1v),
    .cmd_o(cmd),
    .track_end_o(trk_end)
  );

  mtep_note_mem u_mem (
    .clk_i(clk_i),
    .we_i(we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i(re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mtep_out_fifo u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_a_i(push_a),
    .data_a_i(data_a),
    .push_b_i(push_b),
    .data_b_i(data_b),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o(out_data_o),
    .count_o(fifo_cnt)
  );

  assign room = (fifo_cnt <= 3'd2);
  // A byte that opens a new track waits until the table has been cleared.
  assign in_stall_o = !(state_q == ST_IDLE && room && !(done_q && !in_data_i.action));
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    note_res = mk_res(K_NOTE, rdata.start);
    note_res.channel = idx_q[NOTE_AW-1:7];
    note_res.key = idx_q[6:0];
    note_res.level = rdata.vel;
    note_res.duration_ticks = (32'(tick_q) - rdata.start) & DUR_MASK;
    drain_res = mk_res(K_DRAIN, 32'(tick_q));
    drain_res.last_of_run = 1'b1;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pst_d    = pst_q;
    tick_d   = tick_q;
    done_d   = done_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = '0;
    re       = 1'b0;
    raddr    = idx_q;
    push_a   = 1'b0;
    push_b   = 1'b0;
    data_a   = r0;
    data_b   = r1;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == NOTE_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && done_q && !in_data_i.action) begin
          pst_d = PARS_RESET;
          tick_d = '0;
          done_d = 1'b0;
          idx_d = '0;
          state_d = ST_CLEAR;
        end else if (accept) begin
          if (in_data_i.action) begin
            idx_d = '0;
            state_d = ST_SCAN;
          end else begin
            pst_d = pst_n;
            tick_d = tick_n;
            done_d = trk_end;
            case (cmd.op)
              MOP_ON: begin
                we = 1'b1;
                waddr = cmd.idx;
                wdata.valid = 1'b1;
                wdata.vel = cmd.vel;
                wdata.start = cmd.start;
                push_a = r0v;
                push_b = r1v;
              end
              MOP_OFF: begin
                re = 1'b1;
                raddr = cmd.idx;
                idx_d = cmd.idx;
                pend_d = r0;
                pend_v_d = r0v;
                state_d = ST_NOTE;
              end
              default: begin
                push_a = r0v;
                push_b = r1v;
              end
            endcase
          end
        end
      end
      ST_NOTE: begin
        if (rdata.valid) begin
          we = 1'b1;
          push_a = 1'b1;
          data_a = note_res;
          data_a.last_of_run = !pend_v_q;
          push_b = pend_v_q;
          data_b = pend_q;
        end else begin
          push_a = pend_v_q;
          data_a = pend_q;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        re = 1'b1;
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        if (rdata.valid) begin
          we = 1'b1;
          push_a = 1'b1;
          data_a = note_res;
          data_a.last_of_run = 1'b1;
          state_d = ST_IDLE;
        end else if (idx_q == NOTE_LAST) begin
          push_a = 1'b1;
          data_a = drain_res;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pend_d_hold: begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      idx_q    <= '0;
      pst_q    <= PARS_RESET;
      tick_q   <= '0;
      done_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pst_q    <= pst_d;
      tick_q   <= tick_d;
      done_q   <= done_d;
      pend_v_q <= pend_v_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_cnt <= 3'd4)
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_data_i.action && cmd.op == MOP_OFF |=> state_q == ST_NOTE)
    else $error("note-off lookup did not wait for the table read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= K_ERR)
    else $error("result kind out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && !re)
    else $error("table accessed during clearing pass");
`endif

endmodule
